>>> src/sound_chip_filter_6581_macros.svh
// Assertion macros for the sound chip filter block.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SOUND_CHIP_FILTER_6581_MACROS_SVH
`define SOUND_CHIP_FILTER_6581_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SCF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("scf check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SCF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scf check failed");

`endif

>>> src/scf_pkg.sv
// Shared types and constants of the sound chip filter block.
// No dependencies; imported by scf_mac and sound_chip_filter_6581.
package scf_pkg;

  localparam int SAMPLE_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF   = 12;

  localparam int ACC_W   = 40;  // integrator and high-pass node width
  localparam int LO_W    = 20;  // low slice of a multiplier operand
  localparam int CO_W    = 16;  // coefficient operand width
  localparam int RES_SH  = 14;  // resonance fraction bits
  localparam int CUT_SH  = 16;  // cutoff fraction bits
  localparam int OUT_W   = 28;
  localparam int KNEE_W  = 27;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam logic [14:0]       RES_RESET  = 15'd16384;
  localparam logic [KNEE_W-1:0] KNEE_RESET = 27'd3300000;

  typedef enum logic [2:0] {
    REG_ROUTE = 3'd0,
    REG_V3    = 3'd1,
    REG_MODE  = 3'd2,
    REG_VOL   = 3'd3,
    REG_CUT   = 3'd4,
    REG_RES   = 3'd5,
    REG_KNEE  = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RES_LO,
    S_RES_HI,
    S_NODE,
    S_C1_LO,
    S_C1_HI,
    S_BP,
    S_C2_LO,
    S_C2_HI,
    S_LP,
    S_MIX,
    S_VOL_LO,
    S_VOL_HI,
    S_KNEE
  } seq_state_e;

  // en: update the accumulator; hi: high slice, add shifted, else load low slice
  typedef struct packed {
    logic en;
    logic hi;
  } mac_ctl_t;

endpackage

>>> src/sound_chip_filter_6581.sv
// Filter and mixer stage of a 6581-style sound chip.
// Slave stream: one transfer carries voice one, two, three and the external
// sample, SAMPLE_BITS each, packed from the low bits of s_axis_tdata.
// Master stream: one transfer per input carries the 28-bit saturated mix in
// the low bits of m_axis_tdata.
// APB port: seven registers at byte addresses 0, 4, .. 24; pready is always
// high; write only while no sample is in flight.
// Each sample runs through a small sequencer that drives one shared
// two-slice multiply-accumulate unit eight times (resonance feedback, two
// cutoff products, volume). The steps run in order: resonance, high-pass
// node, cutoff, band-pass, cutoff, low-pass, mix, volume, knee. The result
// is registered in the knee step, and the next input is taken only once the
// sequencer is back in idle, after the previous sample is through.
// The output register parts the two sides: while a result waits, the next
// sample is still taken and worked on; it holds in its last step only when
// the previous result has not been taken by then.
// Reset clears both integrators, the registers to their defaults
// (resonance 16384, knee 3300000) and the output valid.
module sound_chip_filter_6581 import scf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // voice_one, voice_two, voice_three, external_in (lowest first), zero pad
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mixed_out in bits 27:0, zero pad
  output logic [31:0]            m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int FIN_W = SUM_W + FRAC_BITS;
  localparam int MIX_W = ((FIN_W > ACC_W) ? FIN_W : ACC_W) + 2;
  localparam int PR_W  = MIX_W + CO_W + 1;

  localparam logic signed [PR_W-1:0] ACC_HI = {{(PR_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [PR_W-1:0] ACC_LO = ~ACC_HI;
  localparam logic signed [PR_W-1:0] OUT_HI = {{(PR_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [PR_W-1:0] OUT_LO = ~OUT_HI;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PR_W-1:0] x);
    logic signed [PR_W-1:0] y;
    begin
      if (x > ACC_HI) begin
        y = ACC_HI;
      end else if (x < ACC_LO) begin
        y = ACC_LO;
      end else begin
        y = x;
      end
      return y[ACC_W-1:0];
    end
  endfunction

  // configuration registers
  logic [3:0]        route_q;
  logic              v3_direct_q;
  logic [2:0]        mode_q;
  logic [3:0]        volume_q;
  logic [CO_W-1:0]   cut_q;
  logic [14:0]       res_q;
  logic [KNEE_W-1:0] knee_q;

  seq_state_e state_q, state_d;
  mac_ctl_t   mac_ctl;
  logic signed [MIX_W-1:0] mac_a;
  logic [CO_W-1:0]         mac_b;
  logic signed [PR_W-1:0]  mac_acc;

  logic signed [SUM_W-1:0] fin_d, fin_q, direct_d, direct_q;
  logic signed [ACC_W-1:0] bp_q, lp_q, node_q;
  logic signed [ACC_W-1:0] node_d, bp_d, lp_d;
  logic signed [MIX_W-1:0] mix_q, mix_d;
  logic [OUT_W-1:0]        out_q, out_d;
  logic                    out_valid_q;
  logic                    in_xfer, out_xfer, knee_go, cfg_wr;

  logic signed [SAMPLE_BITS-1:0] src [4];
  logic signed [PR_W-1:0] mix_sum, o_val, knee_ext, excess, o_knee, o_sat;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign knee_go  = !out_valid_q || m_axis_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 32'(out_q);
  assign pready        = 1'b1;

  // ---------------- configuration port ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_q     <= '0;
      v3_direct_q <= 1'b0;
      mode_q      <= '0;
      volume_q    <= '0;
      cut_q       <= '0;
      res_q       <= RES_RESET;
      knee_q      <= KNEE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[4:2]))
        REG_ROUTE: route_q     <= pwdata[3:0];
        REG_V3:    v3_direct_q <= pwdata[0];
        REG_MODE:  mode_q      <= pwdata[2:0];
        REG_VOL:   volume_q    <= pwdata[3:0];
        REG_CUT:   cut_q       <= pwdata[CO_W-1:0];
        REG_RES:   res_q       <= pwdata[14:0];
        REG_KNEE:  knee_q      <= pwdata[KNEE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_e'(paddr[4:2]))
      REG_ROUTE: prdata = CFG_DW'(route_q);
      REG_V3:    prdata = CFG_DW'(v3_direct_q);
      REG_MODE:  prdata = CFG_DW'(mode_q);
      REG_VOL:   prdata = CFG_DW'(volume_q);
      REG_CUT:   prdata = CFG_DW'(cut_q);
      REG_RES:   prdata = CFG_DW'(res_q);
      REG_KNEE:  prdata = CFG_DW'(knee_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------- source routing ----------------
  always_comb begin
    fin_d    = '0;
    direct_d = '0;
    for (int i = 0; i < 4; i++) begin
      src[i] = signed'(s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]);
      if (route_q[i]) begin
        fin_d = fin_d + SUM_W'(src[i]);
      end else if (i != 2 || v3_direct_q) begin
        direct_d = direct_d + SUM_W'(src[i]);
      end
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid) state_d = S_RES_LO;
      S_RES_LO: state_d = S_RES_HI;
      S_RES_HI: state_d = S_NODE;
      S_NODE:   state_d = S_C1_LO;
      S_C1_LO:  state_d = S_C1_HI;
      S_C1_HI:  state_d = S_BP;
      S_BP:     state_d = S_C2_LO;
      S_C2_LO:  state_d = S_C2_HI;
      S_C2_HI:  state_d = S_LP;
      S_LP:     state_d = S_MIX;
      S_MIX:    state_d = S_VOL_LO;
      S_VOL_LO: state_d = S_VOL_HI;
      S_VOL_HI: state_d = S_KNEE;
      S_KNEE:   if (knee_go) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mac_ctl = '0;
    mac_a   = MIX_W'(bp_q);
    mac_b   = CO_W'(res_q);
    unique case (state_q)
      S_RES_LO, S_RES_HI: begin
        mac_ctl.en = 1'b1;
        mac_ctl.hi = (state_q == S_RES_HI);
        mac_a      = MIX_W'(bp_q);
        mac_b      = CO_W'(res_q);
      end
      S_C1_LO, S_C1_HI: begin
        mac_ctl.en = 1'b1;
        mac_ctl.hi = (state_q == S_C1_HI);
        mac_a      = MIX_W'(node_q);
        mac_b      = cut_q;
      end
      S_C2_LO, S_C2_HI: begin
        mac_ctl.en = 1'b1;
        mac_ctl.hi = (state_q == S_C2_HI);
        mac_a      = MIX_W'(bp_q);
        mac_b      = cut_q;
      end
      S_VOL_LO, S_VOL_HI: begin
        mac_ctl.en = 1'b1;
        mac_ctl.hi = (state_q == S_VOL_HI);
        mac_a      = mix_q;
        mac_b      = CO_W'(volume_q);
      end
      default: ;
    endcase
  end

  scf_mac #(
    .A_W (MIX_W),
    .P_W (PR_W)
  ) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (mac_acc)
  );

  // ---------------- datapath steps ----------------
  always_comb begin
    node_d = sat_acc((PR_W'(fin_q) <<< FRAC_BITS) + (mac_acc >>> RES_SH) + PR_W'(lp_q));
    bp_d   = sat_acc(PR_W'(bp_q) - (mac_acc >>> CUT_SH));
    lp_d   = sat_acc(PR_W'(lp_q) + (mac_acc >>> CUT_SH));

    mix_sum = PR_W'(direct_q) <<< FRAC_BITS;
    if (mode_q[2]) mix_sum = mix_sum - PR_W'(node_q);
    if (mode_q[1]) mix_sum = mix_sum + PR_W'(bp_q);
    if (mode_q[0]) mix_sum = mix_sum + PR_W'(lp_q);
    mix_d = mix_sum[MIX_W-1:0];

    // halve the part above the knee, then clamp
    o_val    = mac_acc >>> FRAC_BITS;
    knee_ext = signed'(PR_W'(knee_q));
    excess   = o_val - knee_ext;
    if (o_val > knee_ext) begin
      o_knee = o_val - (excess >>> 1);
    end else begin
      o_knee = o_val;
    end
    if (o_knee > OUT_HI) begin
      o_sat = OUT_HI;
    end else if (o_knee < OUT_LO) begin
      o_sat = OUT_LO;
    end else begin
      o_sat = o_knee;
    end
    out_d = o_sat[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bp_q        <= '0;
      lp_q        <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_BP) bp_q <= bp_d;
      if (state_q == S_LP) lp_q <= lp_d;
      if (state_q == S_KNEE && knee_go) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      fin_q    <= fin_d;
      direct_q <= direct_d;
    end
    if (state_q == S_NODE) node_q <= node_d;
    if (state_q == S_MIX)  mix_q  <= mix_d;
    if (state_q == S_KNEE && knee_go) out_q <= out_d;
  end

  // ---------------- checks ----------------
  `include "sound_chip_filter_6581_macros.svh"

  `SCF_ASSERT_NXT(a_seq_start, clk_i, rst_ni, in_xfer, state_q == S_RES_LO)
  `SCF_ASSERT_IMP(a_result_source, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_KNEE))
  `SCF_ASSERT_NXT(a_knee_hold, clk_i, rst_ni, state_q == S_KNEE && !knee_go, state_q == S_KNEE)
  `SCF_ASSERT_IMP(a_bp_update, clk_i, rst_ni, !$stable(bp_q), $past(state_q == S_BP))

endmodule

>>> src/scf_mac.sv
// Shared multiply-accumulate unit: a wide signed operand times an unsigned
// coefficient, done as two slices, low then high. Depends on scf_pkg.
module scf_mac import scf_pkg::*; #(
  parameter int A_W = 42,
  parameter int P_W = A_W + CO_W + 1
) (
  input  logic                  clk_i,
  input  mac_ctl_t              ctl_i,
  input  logic signed [A_W-1:0] a_i,
  input  logic [CO_W-1:0]       b_i,
  output logic signed [P_W-1:0] acc_o
);

  localparam int HI_W = A_W - LO_W;
  localparam int MA_W = (HI_W > LO_W) ? HI_W : LO_W + 1;
  localparam int M_W  = MA_W + CO_W + 1;

  logic signed [MA_W-1:0] part;
  logic signed [CO_W:0]   coef;
  logic signed [M_W-1:0]  prod;
  logic signed [P_W-1:0]  prod_ext;
  logic signed [P_W-1:0]  acc_d, acc_q;

  always_comb begin
    if (ctl_i.hi) begin
      part = MA_W'(signed'(a_i[A_W-1:LO_W]));
    end else begin
      part = signed'(MA_W'({1'b0, a_i[LO_W-1:0]}));
    end
    coef     = signed'({1'b0, b_i});
    prod     = part * coef;
    prod_ext = P_W'(prod);
    if (ctl_i.hi) begin
      acc_d = acc_q + (prod_ext <<< LO_W);
    end else begin
      acc_d = prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
